// ----- rtl/efs_pkg.sv -----
// Shared types, constants and constant tables of the exp(-z) escape shader.
`default_nettype none

package efs_pkg;

    // Fixed-point format of the iteration.
    localparam int FRAC     = 40;
    localparam int WORD_W   = 64;
    localparam int ACC_W    = 2 * WORD_W;
    localparam int IDX_W    = $clog2(FRAC + 1);
    localparam int IN_W     = 32;
    localparam int IN_FRAC  = 24;
    localparam int IN_SHIFT = FRAC - IN_FRAC;
    localparam int LIMIT_W  = 16;
    localparam int Q_W      = 8;
    localparam int COL_W    = 8;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Exponent at which the mantissa is clamped, the point then escapes.
    localparam int EXP_CLAMP = 13;

    // Palette: index advances by a fixed step per iteration, modulo the ramp length.
    localparam int PAL_STEP = 42;
    localparam int PAL_LEN  = 1536;
    localparam int PAL_W    = $clog2(PAL_LEN);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    typedef logic signed [WORD_W-1:0] t_word;
    typedef t_word t_tab [0:FRAC];

    // Escape radius squared and convergence threshold at 2*FRAC fraction bits.
    localparam logic [ACC_W-1:0] ESC_THR  = ACC_W'(100) << (2 * FRAC);
    localparam logic [ACC_W-1:0] CONV_THR =
        (ACC_W'(1) << (2 * FRAC)) / ACC_W'(64'd10000000000000000);

    localparam real SCALE_R = 2.0 ** FRAC;
    localparam real PI_R    = 4.0 * $atan(1.0);

    function automatic t_word to_fx(real v);
        return t_word'(longint'(v * SCALE_R));
    endfunction

    function automatic t_tab atn_tab();
        t_tab tab;
        for (int i = 0; i <= FRAC; i++) begin
            tab[i] = to_fx($atan(2.0 ** (-i)));
        end
        return tab;
    endfunction

    function automatic t_tab lnt_tab();
        t_tab tab;
        tab[0] = '0;
        for (int i = 1; i <= FRAC; i++) begin
            tab[i] = to_fx($ln(1.0 + 2.0 ** (-i)));
        end
        return tab;
    endfunction

    // Minus the log of the circular CORDIC gain.
    function automatic t_word lnk_calc();
        real s;
        s = 0.0;
        for (int i = 0; i <= FRAC; i++) begin
            s = s + $ln(1.0 + 2.0 ** (-2 * i));
        end
        return -to_fx(s / 2.0);
    endfunction

    localparam t_tab  ATN_TAB = atn_tab();
    localparam t_tab  LNT_TAB = lnt_tab();
    localparam t_word LN2     = to_fx($ln(2.0));
    localparam t_word LNK     = lnk_calc();
    localparam t_word PI_F    = to_fx(PI_R);
    localparam t_word HALFPI  = to_fx(PI_R / 2.0);
    localparam t_word TWOPI   = to_fx(PI_R * 2.0);

    typedef enum logic [0:0] {
        REG_LIMIT = 1'b0
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ESC_MUL,
        ST_ESC_WAIT,
        ST_EXP_T,
        ST_QDIV,
        ST_MANT,
        ST_SCALE,
        ST_THRED,
        ST_THFIX,
        ST_HALF,
        ST_ROT,
        ST_DIFF,
        ST_DIST_MUL,
        ST_DIST_WAIT,
        ST_PAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
    } t_mul_req;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] sum;
    } t_mul_rsp;

    // Red in the lowest byte.
    typedef struct packed {
        logic [COL_W-1:0] blue;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] red;
    } t_colour;

endpackage

`default_nettype wire

// ----- rtl/efs_mul.sv -----
// Sum of two squares through one shared 32x32 multiplier and a 128-bit accumulator.
`default_nettype none

module efs_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire efs_pkg::t_mul_req i_req,
    output efs_pkg::t_mul_rsp      o_rsp
);
    import efs_pkg::*;

    localparam int HALF_W    = WORD_W / 2;
    localparam int STEP_W    = 4;
    localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(8);

    logic [WORD_W-1:0] r_ua, r_ub;
    logic [STEP_W-1:0] r_k;
    logic              r_busy, r_pv, r_done;
    logic [WORD_W-1:0] r_prod;
    logic [1:0]        r_psh;
    logic [ACC_W-1:0]  r_acc;

    logic [WORD_W-1:0] w_opnd;
    logic [HALF_W-1:0] w_ml, w_mr;
    logic [WORD_W-1:0] w_prod;
    logic [ACC_W-1:0]  w_shifted;

    // Steps 0..3 square the first operand, 4..7 the second; halves low/high.
    always_comb begin
        w_opnd    = r_k[2] ? r_ub : r_ua;
        w_ml      = r_k[1] ? w_opnd[WORD_W-1:HALF_W] : w_opnd[HALF_W-1:0];
        w_mr      = r_k[0] ? w_opnd[WORD_W-1:HALF_W] : w_opnd[HALF_W-1:0];
        w_prod    = w_ml * w_mr;
        w_shifted = {{WORD_W{1'b0}}, r_prod} << (HALF_W * r_psh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_ua   <= i_req.a[WORD_W-1] ? WORD_W'(-i_req.a) : WORD_W'(i_req.a);
                r_ub   <= i_req.b[WORD_W-1] ? WORD_W'(-i_req.b) : WORD_W'(i_req.b);
                r_k    <= '0;
                r_busy <= 1'b1;
                r_pv   <= 1'b0;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_pv) begin
                    r_acc <= r_acc + w_shifted;
                end
                if (r_k != MUL_STEPS) begin
                    r_prod <= w_prod;
                    r_psh  <= 2'(r_k[1]) + 2'(r_k[0]);
                    r_pv   <= 1'b1;
                    r_k    <= r_k + 1'b1;
                end else begin
                    r_pv   <= 1'b0;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sum  = r_acc;

endmodule

`default_nettype wire

// ----- rtl/efs_core.sv -----
// Iteration sequencer: exp(-z) by shift-add steps, escape and convergence tests, palette.
`default_nettype none

module efs_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [efs_pkg::IN_W-1:0] i_coord_re,
    input  wire logic signed [efs_pkg::IN_W-1:0] i_coord_im,
    input  wire logic [efs_pkg::LIMIT_W-1:0]   i_limit,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output efs_pkg::t_colour                   o_res
);
    import efs_pkg::*;

    localparam logic [2:0] SEG_CYAN_UP   = 3'd0;
    localparam logic [2:0] SEG_BLUE_DOWN = 3'd1;
    localparam logic [2:0] SEG_RED_UP    = 3'd2;
    localparam logic [2:0] SEG_GRN_DOWN  = 3'd3;
    localparam logic [2:0] SEG_BLUE_UP   = 3'd4;
    localparam logic [COL_W-1:0] FULL    = '1;

    t_state              r_state, n_state;
    t_word               r_re, n_re, r_im, n_im, r_lre, n_lre, r_lim, n_lim;
    t_word               r_t, n_t, r_m, n_m, r_x, n_x, r_y, n_y, r_th, n_th;
    logic signed [Q_W-1:0] r_q, n_q;
    logic [IDX_W-1:0]    r_j, n_j;
    logic [LIMIT_W-1:0]  r_iters, n_iters;
    logic [PAL_W-1:0]    r_pidx, n_pidx;
    t_colour             r_col, n_col;

    t_mul_req            w_req;
    t_mul_rsp            w_rsp;
    t_word               w_diff, w_sx, w_sy;
    logic [Q_W-1:0]      w_nq;
    logic [PAL_W:0]      w_pnext;

    efs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_re    <= n_re;
        r_im    <= n_im;
        r_lre   <= n_lre;
        r_lim   <= n_lim;
        r_t     <= n_t;
        r_m     <= n_m;
        r_x     <= n_x;
        r_y     <= n_y;
        r_th    <= n_th;
        r_q     <= n_q;
        r_j     <= n_j;
        r_iters <= n_iters;
        r_pidx  <= n_pidx;
        r_col   <= n_col;
    end

    always_comb begin
        n_state = r_state;
        n_re    = r_re;
        n_im    = r_im;
        n_lre   = r_lre;
        n_lim   = r_lim;
        n_t     = r_t;
        n_m     = r_m;
        n_x     = r_x;
        n_y     = r_y;
        n_th    = r_th;
        n_q     = r_q;
        n_j     = r_j;
        n_iters = r_iters;
        n_pidx  = r_pidx;
        n_col   = r_col;
        w_req.start = 1'b0;
        w_req.a     = (r_state == ST_ESC_MUL) ? r_re : r_t;
        w_req.b     = (r_state == ST_ESC_MUL) ? r_im : r_th;
        w_diff  = '0;
        w_sx    = r_x >>> r_j;
        w_sy    = r_y >>> r_j;
        w_nq    = Q_W'(-r_q);
        w_pnext = (PAL_W + 1)'(r_pidx) + (PAL_W + 1)'(PAL_STEP);
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_re    = t_word'(i_coord_re) <<< IN_SHIFT;
                    n_im    = t_word'(i_coord_im) <<< IN_SHIFT;
                    n_lre   = t_word'(i_coord_re) <<< IN_SHIFT;
                    n_lim   = t_word'(i_coord_im) <<< IN_SHIFT;
                    n_iters = '0;
                    n_pidx  = '0;
                    n_state = ST_ESC_MUL;
                end
            end
            ST_ESC_MUL: begin
                w_req.start = 1'b1;
                n_state     = ST_ESC_WAIT;
            end
            ST_ESC_WAIT: begin
                if (w_rsp.done) begin
                    if (w_rsp.sum >= ESC_THR || r_iters >= i_limit) begin
                        n_state = ST_PAL;
                    end else begin
                        n_state = ST_EXP_T;
                    end
                end
            end
            ST_EXP_T: begin
                n_t     = LNK - r_re;
                n_q     = '0;
                n_state = ST_QDIV;
            end
            ST_QDIV: begin
                // Floor division by ln 2, one step per cycle.
                w_diff = r_t - LN2;
                if (r_t[WORD_W-1]) begin
                    n_t = r_t + LN2;
                    n_q = r_q - 1'b1;
                end else if (!w_diff[WORD_W-1]) begin
                    n_t = w_diff;
                    n_q = r_q + 1'b1;
                end else begin
                    n_m     = t_word'(1) <<< FRAC;
                    n_j     = IDX_W'(1);
                    n_state = ST_MANT;
                end
            end
            ST_MANT: begin
                w_diff = r_t - LNT_TAB[r_j];
                if (!w_diff[WORD_W-1]) begin
                    n_t = w_diff;
                    n_m = r_m + (r_m >>> r_j);
                end
                if (r_j == IDX_W'(FRAC)) begin
                    n_state = ST_SCALE;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_SCALE: begin
                if (r_q >= Q_W'(EXP_CLAMP)) begin
                    n_m = t_word'(1) <<< (EXP_CLAMP + FRAC);
                end else if (!r_q[Q_W-1]) begin
                    n_m = r_m <<< r_q[3:0];
                end else if (w_nq >= Q_W'(63)) begin
                    n_m = '0;
                end else begin
                    n_m = r_m >>> w_nq[5:0];
                end
                n_th    = -r_im;
                n_state = ST_THRED;
            end
            ST_THRED: begin
                if (r_th[WORD_W-1]) begin
                    n_th = r_th + TWOPI;
                end else if (r_th >= TWOPI) begin
                    n_th = r_th - TWOPI;
                end else begin
                    n_state = ST_THFIX;
                end
            end
            ST_THFIX: begin
                if (r_th > PI_F) begin
                    n_th = r_th - TWOPI;
                end
                n_state = ST_HALF;
            end
            ST_HALF: begin
                if (r_th > HALFPI) begin
                    n_x  = -r_m;
                    n_th = r_th - PI_F;
                end else if (r_th < -HALFPI) begin
                    n_x  = -r_m;
                    n_th = r_th + PI_F;
                end else begin
                    n_x = r_m;
                end
                n_y     = '0;
                n_j     = '0;
                n_state = ST_ROT;
            end
            ST_ROT: begin
                if (!r_th[WORD_W-1]) begin
                    n_x  = r_x - w_sy;
                    n_y  = r_y + w_sx;
                    n_th = r_th - ATN_TAB[r_j];
                end else begin
                    n_x  = r_x + w_sy;
                    n_y  = r_y - w_sx;
                    n_th = r_th + ATN_TAB[r_j];
                end
                if (r_j == IDX_W'(FRAC)) begin
                    n_state = ST_DIFF;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_DIFF: begin
                n_re    = r_x;
                n_im    = r_y;
                n_t     = r_lre - r_x;
                n_th    = r_lim - r_y;
                n_state = ST_DIST_MUL;
            end
            ST_DIST_MUL: begin
                w_req.start = 1'b1;
                n_state     = ST_DIST_WAIT;
            end
            ST_DIST_WAIT: begin
                if (w_rsp.done) begin
                    if (w_rsp.sum <= CONV_THR) begin
                        n_state = ST_PAL;
                    end else begin
                        n_lre   = r_re;
                        n_lim   = r_im;
                        n_iters = r_iters + 1'b1;
                        if (w_pnext >= (PAL_W + 1)'(PAL_LEN)) begin
                            n_pidx = PAL_W'(w_pnext - (PAL_W + 1)'(PAL_LEN));
                        end else begin
                            n_pidx = PAL_W'(w_pnext);
                        end
                        n_state = ST_ESC_MUL;
                    end
                end
            end
            ST_PAL: begin
                n_col = '0;
                if (r_iters < i_limit) begin
                    unique case (r_pidx[PAL_W-1:COL_W])
                        SEG_CYAN_UP: begin
                            n_col.green = r_pidx[COL_W-1:0];
                            n_col.blue  = FULL;
                        end
                        SEG_BLUE_DOWN: begin
                            n_col.green = FULL;
                            n_col.blue  = FULL - r_pidx[COL_W-1:0];
                        end
                        SEG_RED_UP: begin
                            n_col.red   = r_pidx[COL_W-1:0];
                            n_col.green = FULL;
                        end
                        SEG_GRN_DOWN: begin
                            n_col.red   = FULL;
                            n_col.green = FULL - r_pidx[COL_W-1:0];
                        end
                        SEG_BLUE_UP: begin
                            n_col.red  = FULL;
                            n_col.blue = r_pidx[COL_W-1:0];
                        end
                        default: begin
                            n_col.red  = FULL - r_pidx[COL_W-1:0];
                            n_col.blue = FULL;
                        end
                    endcase
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res = r_col;

endmodule

`default_nettype wire

// ----- rtl/exp_fixed_point_escape_shader_unit.sv -----
// Top level of the exp(-z) escape-time shader: stream ports, register port, result register.
//
//  Port group     | Direction | Contents
//  ---------------+-----------+-----------------------------------------------
//  s_axis_*       | in        | start point: coord_re [31:0], coord_im [63:32]
//  m_axis_*       | out       | colour: red [7:0], green [15:8], blue [23:16]
//  APB (psel...)  | in/out    | iteration_limit at byte address 0
//
// A point occupies the unit until it escapes, converges or reaches the
// iteration limit. Each iteration spends its time in the shift-add sequencer:
// exponent reduction, the mantissa steps, 41 CORDIC rotation steps and two
// sum-of-squares passes through the one 32x32 multiplier. Reset is synchronous
// and active low; it clears the sequencer and the output valid flag and sets
// the iteration limit to 100. The input side is not ready while a point is
// being worked on. A finished colour waits in the output register, so the next
// point may be accepted while the downstream side stalls; the sequencer only
// waits when a second colour is ready and the register is still full.
`default_nettype none

module exp_fixed_point_escape_shader_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input transactions.
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [2*efs_pkg::IN_W-1:0]    s_axis_tdata,  // coord_re, coord_im
    // Result transactions.
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [3*efs_pkg::COL_W-1:0]        m_axis_tdata,  // red, green, blue
    // Register port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [efs_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [efs_pkg::PDATA_W-1:0]   pwdata,
    output logic [efs_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import efs_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic               r_out_valid;
    t_colour            r_out_col;

    logic               w_res_valid, w_res_ready, w_in_ready;
    t_colour            w_res;

    // The register port never stalls; a write lands on the access cycle.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LIMIT)) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_LIMIT) begin
            prdata = PDATA_W'(r_limit);
        end
    end

    efs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (w_in_ready),
        .i_coord_re  (s_axis_tdata[IN_W-1:0]),
        .i_coord_im  (s_axis_tdata[2*IN_W-1:IN_W]),
        .i_limit     (r_limit),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign s_axis_tready = w_in_ready;

    // The output register takes a new colour whenever it is empty or being drained.
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out_col <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_col;

    // A point keeps the unit busy for many cycles once taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted again right after a transaction");

    // Every colour is black or lies on a ramp with one channel at full scale.
    a_colour_on_palette: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata == '0) || (r_out_col.red == '1) ||
                          (r_out_col.green == '1) || (r_out_col.blue == '1))
        else $error("colour off the palette");

    // Reset restores the default limit and empties the output register.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_limit == LIMIT_RESET) && !m_axis_tvalid)
        else $error("reset state wrong");

endmodule

`default_nettype wire
